// ----- hdl/chrl_pkg.sv -----
// chrl_pkg: shared types, constants and command codes for the hash ring lookup.
// No dependencies; all other files but chrl_ram use it (the RTL by scoped names).
`default_nettype none
package chrl_pkg;
  localparam int RING_DEPTH = 256;
  localparam int NODE_COUNT = 64;
  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam int NODE_W = 6;
  localparam int KEY_W = 64;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_FIND = 3'd1,
    CMD_NEXT = 3'd2,
    CMD_FIND_AVAIL = 3'd3,
    CMD_CONT_AVAIL = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_DUP = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_BS_RD, S_BS_WAIT, S_BS_CMP, S_INS_CHK, S_SHIFT_RD, S_SHIFT_WAIT,
    S_SHIFT_WR, S_INS_WR, S_POS, S_SKIP_RD, S_SKIP_WAIT, S_SKIP_CHK, S_OUT_RD,
    S_OUT_WAIT, S_RESP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture the input transaction
    logic bs_init;    // start binary search
    logic bs_step;    // update lo/hi from read data
    logic rd_mid;     // read at mid
    logic rd_cur;     // read at cursor
    logic rd_shift;   // read at shift source
    logic wr_shift;   // write shifted entry
    logic shift_dec;  // move shift pointer down
    logic wr_new;     // write new point
    logic pos_find;   // cursor from search result
    logic pos_next;   // next step
    logic pos_cont;   // continue-available entry
    logic skip_adv;   // advance past a down node
    logic set_dup;
    logic set_full;
    logic set_miss;
    logic set_hit;
    logic out_valid_set;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic bs_done;
    logic dup;
    logic full;
    logic shift_done;
    logic empty;
    logic node_up;
    logic skip_miss;
    logic miss_now;
    logic out_busy;
  } stat_t;
endpackage
`default_nettype wire

// ----- hdl/chrl_if.sv -----
// chrl_if: valid/ready channel interfaces for request and result transactions.
// Depends on chrl_pkg for field widths.
`default_nettype none
interface chrl_req_if;
  logic valid;
  logic ready;
  logic [2:0] cmd;
  logic [chrl_pkg::KEY_W-1:0] key_hash;
  logic [chrl_pkg::NODE_W-1:0] node_id;
  modport source(output valid, cmd, key_hash, node_id, input ready);
  modport sink(input valid, cmd, key_hash, node_id, output ready);
endinterface

interface chrl_rsp_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [chrl_pkg::NODE_W-1:0] chosen_node;
  logic wrapped_out;
  logic [chrl_pkg::KEY_W-1:0] point_key;
  modport source(output valid, status, chosen_node, wrapped_out, point_key, input ready);
  modport sink(input valid, status, chosen_node, wrapped_out, point_key, output ready);
endinterface
`default_nettype wire

// ----- hdl/chrl_ram.sv -----
// chrl_ram: generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module chrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- hdl/chrl_datapath.sv -----
// chrl_datapath: ring memory, search registers, cursor and result register.
// Depends on chrl_pkg and chrl_ram.
`default_nettype none
module chrl_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire chrl_pkg::ctrl_t               ctrl,
  output chrl_pkg::stat_t                    stat,
  input  wire logic [2:0]                    in_cmd,
  input  wire logic [chrl_pkg::KEY_W-1:0]    in_key,
  input  wire logic [chrl_pkg::NODE_W-1:0]   in_node,
  input  wire logic                          cfg_we,
  input  wire logic [63:0]                   cfg_wdata,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_status,
  output logic [chrl_pkg::NODE_W-1:0]        out_node,
  output logic                               out_wrapped,
  output logic [chrl_pkg::KEY_W-1:0]         out_key
);
  localparam int IW = chrl_pkg::IDX_W;
  localparam int CW = chrl_pkg::CNT_W;

  logic [63:0] mask_r;
  logic [chrl_pkg::KEY_W-1:0] key_r;
  logic [chrl_pkg::NODE_W-1:0] node_r;
  logic [2:0] cmd_r;
  logic [CW-1:0] count_r, cursor_r, lo_r, hi_r, sp_r;
  logic [CW:0] guard_r;
  logic wrap_r, ov_r;
  logic [1:0] ost_r;
  logic [chrl_pkg::NODE_W-1:0] onode_r;
  logic [chrl_pkg::KEY_W-1:0] okey_r;
  logic owrap_r;

  logic [CW-1:0] mid;
  logic [IW-1:0] addr;
  logic we;
  logic [chrl_pkg::KEY_W-1:0] kw, kr;
  logic [chrl_pkg::NODE_W-1:0] nw, nr;
  logic [CW-1:0] cur_inc;
  logic [6:0] node_red;
  logic [2:0] cmd_cur;

  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  assign cur_inc = cursor_r + CW'(1);
  assign node_red = 7'(in_node) % 7'(chrl_pkg::NODE_COUNT);
  // command of the transaction in flight (live on the accepting cycle)
  assign cmd_cur = ctrl.load ? in_cmd : cmd_r;

  // memory address and write data selection
  always_comb begin
    addr = cursor_r[IW-1:0];
    if (ctrl.rd_mid) addr = mid[IW-1:0];
    if (ctrl.rd_shift) addr = sp_r[IW-1:0] - IW'(1);
    if (ctrl.wr_shift) addr = sp_r[IW-1:0];
    if (ctrl.wr_new) addr = lo_r[IW-1:0];
    we = ctrl.wr_shift | ctrl.wr_new;
    kw = ctrl.wr_new ? key_r : kr;
    nw = ctrl.wr_new ? node_r : nr;
  end

  chrl_ram #(.WIDTH(chrl_pkg::KEY_W), .DEPTH(chrl_pkg::RING_DEPTH)) u_keys (
    .clk(clk), .we(we), .addr(addr), .wdata(kw), .rdata(kr));
  chrl_ram #(.WIDTH(chrl_pkg::NODE_W), .DEPTH(chrl_pkg::RING_DEPTH)) u_nodes (
    .clk(clk), .we(we), .addr(addr), .wdata(nw), .rdata(nr));

  // status back to the controller
  always_comb begin
    stat.bs_done = (lo_r >= hi_r);
    stat.dup = (lo_r < count_r) && (kr == key_r);
    stat.full = (count_r >= CW'(chrl_pkg::RING_DEPTH));
    stat.shift_done = (sp_r == lo_r);
    stat.empty = (count_r == '0);
    stat.node_up = mask_r[nr];
    stat.skip_miss = (cur_inc >= count_r && wrap_r) || (guard_r == '0);
    stat.miss_now = (cursor_r >= count_r);
    stat.out_busy = ov_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '1;
      count_r <= '0;
      cursor_r <= '0;
      wrap_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (cfg_we) mask_r <= cfg_wdata;
      if (ov_r && out_ready) ov_r <= 1'b0;
      if (ctrl.out_valid_set) ov_r <= 1'b1;
      if (ctrl.wr_new) count_r <= count_r + CW'(1);
      // cursor and wrap flag updates
      if (ctrl.pos_find) begin
        if (lo_r >= count_r) begin
          cursor_r <= '0;
          wrap_r <= 1'b1;
        end else begin
          cursor_r <= lo_r;
          wrap_r <= 1'b0;
        end
      end
      if (ctrl.pos_next) begin
        if (cur_inc >= count_r) begin
          if (!wrap_r) begin
            wrap_r <= 1'b1;
            cursor_r <= '0;
          end else begin
            cursor_r <= count_r;
          end
        end else begin
          cursor_r <= cur_inc;
        end
      end
      if (ctrl.pos_cont && cursor_r >= count_r) begin
        wrap_r <= 1'b1;
        cursor_r <= '0;
      end
      if (ctrl.skip_adv) begin
        if (cur_inc >= count_r) begin
          if (!wrap_r) begin
            wrap_r <= 1'b1;
            cursor_r <= '0;
          end else begin
            cursor_r <= count_r;
          end
        end else begin
          cursor_r <= cur_inc;
        end
        if (guard_r == '0) cursor_r <= count_r;
      end
    end
  end

  // search, shift and result registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      key_r <= in_key;
      node_r <= chrl_pkg::NODE_W'(node_red);
      cmd_r <= in_cmd;
    end
    if (ctrl.bs_init) begin
      lo_r <= '0;
      hi_r <= count_r;
    end
    if (ctrl.bs_step) begin
      if (kr < key_r) lo_r <= mid + CW'(1);
      else hi_r <= mid;
    end
    if (ctrl.set_full) sp_r <= count_r;
    if (ctrl.shift_dec) sp_r <= sp_r - CW'(1);
    if (ctrl.pos_find || ctrl.pos_cont) guard_r <= {count_r, 1'b0};
    if (ctrl.skip_adv) guard_r <= guard_r - (CW+1)'(1);
    if (ctrl.set_dup) begin
      ost_r <= chrl_pkg::ST_DUP;
      onode_r <= nr;
      okey_r <= kr;
    end
    if (ctrl.wr_new) begin
      ost_r <= chrl_pkg::ST_OK;
      onode_r <= node_r;
      okey_r <= key_r;
    end
    if (ctrl.set_miss) begin
      ost_r <= (cmd_cur == chrl_pkg::CMD_INSERT) ? chrl_pkg::ST_FULL : chrl_pkg::ST_MISS;
      onode_r <= '0;
      okey_r <= '0;
    end
    if (ctrl.set_hit) begin
      ost_r <= chrl_pkg::ST_OK;
      onode_r <= nr;
      okey_r <= kr;
    end
    if (ctrl.out_valid_set) owrap_r <= wrap_r;
  end

  assign out_valid = ov_r;
  assign out_status = ost_r;
  assign out_node = onode_r;
  assign out_wrapped = owrap_r;
  assign out_key = okey_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(chrl_pkg::RING_DEPTH)) else $error("point count overflow");
  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= count_r || ctrl.wr_new || $past(ctrl.wr_new))
    else $error("cursor past ring end");
  a_grow_one: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wr_new |=> count_r == $past(count_r) + CW'(1)) else $error("bad insert count");
endmodule
`default_nettype wire

// ----- hdl/chrl_ctrl.sv -----
// chrl_ctrl: sequencer for insert, find, next and skip commands.
// Depends on chrl_pkg.
`default_nettype none
module chrl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        in_cmd,
  input  wire chrl_pkg::stat_t   stat,
  output chrl_pkg::ctrl_t        ctrl
);
  chrl_pkg::state_t state_r, state_nxt;
  logic [2:0] cmd_r, cmd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= chrl_pkg::S_IDLE;
      cmd_r <= '0;
    end else begin
      state_r <= state_nxt;
      cmd_r <= cmd_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    ctrl = '0;
    in_ready = (state_r == chrl_pkg::S_IDLE) && !stat.out_busy;
    unique case (state_r)
      chrl_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          ctrl.load = 1'b1;
          ctrl.bs_init = 1'b1;
          cmd_nxt = in_cmd;
          unique case (in_cmd)
            chrl_pkg::CMD_INSERT, chrl_pkg::CMD_FIND, chrl_pkg::CMD_FIND_AVAIL:
              state_nxt = stat.empty && in_cmd != chrl_pkg::CMD_INSERT
                ? chrl_pkg::S_RESP : chrl_pkg::S_BS_RD;
            chrl_pkg::CMD_NEXT, chrl_pkg::CMD_CONT_AVAIL:
              state_nxt = stat.empty ? chrl_pkg::S_RESP : chrl_pkg::S_POS;
            default: state_nxt = chrl_pkg::S_RESP;
          endcase
          if (state_nxt == chrl_pkg::S_RESP) ctrl.set_miss = 1'b1;
        end
      end
      chrl_pkg::S_BS_RD: begin
        ctrl.rd_mid = 1'b1;
        state_nxt = stat.bs_done ? chrl_pkg::S_INS_CHK : chrl_pkg::S_BS_WAIT;
        if (stat.bs_done) ctrl.rd_cur = 1'b0;
      end
      chrl_pkg::S_BS_WAIT: begin
        ctrl.rd_mid = 1'b1;
        state_nxt = chrl_pkg::S_BS_CMP;
      end
      chrl_pkg::S_BS_CMP: begin
        ctrl.bs_step = 1'b1;
        state_nxt = chrl_pkg::S_BS_RD;
      end
      chrl_pkg::S_INS_CHK: begin
        // lo is the first index with key >= request; data read at lo settled
        if (cmd_r != chrl_pkg::CMD_INSERT) begin
          state_nxt = chrl_pkg::S_POS;
        end else if (stat.dup) begin
          ctrl.set_dup = 1'b1;
          state_nxt = chrl_pkg::S_RESP;
        end else if (stat.full) begin
          ctrl.set_miss = 1'b1;
          state_nxt = chrl_pkg::S_RESP;
        end else begin
          ctrl.set_full = 1'b1;
          state_nxt = chrl_pkg::S_SHIFT_RD;
        end
        ctrl.rd_mid = 1'b1;
      end
      chrl_pkg::S_SHIFT_RD: begin
        if (stat.shift_done) state_nxt = chrl_pkg::S_INS_WR;
        else begin
          ctrl.rd_shift = 1'b1;
          state_nxt = chrl_pkg::S_SHIFT_WAIT;
        end
      end
      chrl_pkg::S_SHIFT_WAIT: begin
        ctrl.rd_shift = 1'b1;
        state_nxt = chrl_pkg::S_SHIFT_WR;
      end
      chrl_pkg::S_SHIFT_WR: begin
        ctrl.wr_shift = 1'b1;
        ctrl.shift_dec = 1'b1;
        state_nxt = chrl_pkg::S_SHIFT_RD;
      end
      chrl_pkg::S_INS_WR: begin
        ctrl.wr_new = 1'b1;
        state_nxt = chrl_pkg::S_RESP;
      end
      chrl_pkg::S_POS: begin
        unique case (cmd_r)
          chrl_pkg::CMD_FIND, chrl_pkg::CMD_FIND_AVAIL: ctrl.pos_find = 1'b1;
          chrl_pkg::CMD_NEXT: ctrl.pos_next = 1'b1;
          default: ctrl.pos_cont = 1'b1;
        endcase
        state_nxt = (cmd_r == chrl_pkg::CMD_FIND_AVAIL || cmd_r == chrl_pkg::CMD_CONT_AVAIL)
          ? chrl_pkg::S_SKIP_RD : chrl_pkg::S_OUT_RD;
      end
      chrl_pkg::S_SKIP_RD: begin
        ctrl.rd_cur = 1'b1;
        state_nxt = chrl_pkg::S_SKIP_WAIT;
      end
      chrl_pkg::S_SKIP_WAIT: state_nxt = chrl_pkg::S_SKIP_CHK;
      chrl_pkg::S_SKIP_CHK: begin
        if (stat.node_up) begin
          ctrl.set_hit = 1'b1;
          state_nxt = chrl_pkg::S_RESP;
        end else if (stat.skip_miss) begin
          ctrl.skip_adv = 1'b1;
          ctrl.set_miss = 1'b1;
          state_nxt = chrl_pkg::S_RESP;
        end else begin
          ctrl.skip_adv = 1'b1;
          state_nxt = chrl_pkg::S_SKIP_RD;
        end
      end
      chrl_pkg::S_OUT_RD: begin
        state_nxt = chrl_pkg::S_OUT_WAIT;
      end
      chrl_pkg::S_OUT_WAIT: begin
        if (stat.miss_now) ctrl.set_miss = 1'b1;
        else ctrl.set_hit = 1'b1;
        state_nxt = chrl_pkg::S_RESP;
      end
      chrl_pkg::S_RESP: begin
        ctrl.out_valid_set = 1'b1;
        state_nxt = chrl_pkg::S_IDLE;
      end
      default: state_nxt = chrl_pkg::S_IDLE;
    endcase
  end

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.wr_new && ctrl.wr_shift)) else $error("two ring writes at once");
  a_resp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_valid_set |=> state_r == chrl_pkg::S_IDLE) else $error("resp not followed by idle");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load |-> !stat.out_busy) else $error("accepted while result pending");
endmodule
`default_nettype wire

// ----- hdl/consistent_hash_ring_lookup_core.sv -----
// consistent_hash_ring_lookup_core: top level of the hash ring lookup block.
// Depends on chrl_pkg, chrl_if, chrl_ctrl, chrl_datapath, chrl_ram.
//
// Usage: requests arrive on in_ (valid/ready), one result per request leaves
// on out_ (valid/ready). cfg_we/cfg_wdata write the 64-bit node availability
// mask (reset all ones); write it only while the block is idle.
// One request at a time. Binary search reads, waits and compares (S_BS_RD,
// S_BS_WAIT, S_BS_CMP) per halving of the ring; insert moves each point up
// through the single-port ring RAM by a read, a wait and a write; a skipped
// down node is read, waited on and checked. Next runs through S_POS,
// S_OUT_RD, S_OUT_WAIT and S_RESP; unknown commands and lookups on an empty
// ring go straight to S_RESP. Reset (synchronous, rst_n low) empties the
// ring, clears cursor, wrap flag and pending result and sets the mask; ring
// RAM contents are not cleared, only entries below the point count are used.
// While a result waits on a stalled receiver no new request is accepted.
`default_nettype none
module consistent_hash_ring_lookup_core (
  input wire logic clk,
  input wire logic rst_n,
  chrl_req_if.sink in_ch,
  chrl_rsp_if.source out_ch,
  input wire logic cfg_we,
  input wire logic [63:0] cfg_wdata
);
  chrl_pkg::ctrl_t ctrl;
  chrl_pkg::stat_t stat;

  chrl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_cmd(in_ch.cmd), .stat(stat), .ctrl(ctrl));

  chrl_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat),
    .in_cmd(in_ch.cmd), .in_key(in_ch.key_hash), .in_node(in_ch.node_id),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_status(out_ch.status),
    .out_node(out_ch.chosen_node), .out_wrapped(out_ch.wrapped_out),
    .out_key(out_ch.point_key));
endmodule
`default_nettype wire

// ----- sim/consistent_hash_ring_lookup_core_tb.sv -----
// Testbench for consistent_hash_ring_lookup_core: a queue-fed driver, a result monitor
// and a behavioral ring model that predicts each result transaction.
// Depends on chrl_pkg, chrl_if and the RTL of the block.
`default_nettype none
module consistent_hash_ring_lookup_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import chrl_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int TAIL_CYCLES = 100;

  typedef struct packed {
    logic [2:0] cmd;
    logic [KEY_W-1:0] key_hash;
    logic [NODE_W-1:0] node_id;
  } lookup_req_t;

  typedef struct packed {
    status_t status;
    logic [NODE_W-1:0] chosen_node;
    logic wrapped_out;
    logic [KEY_W-1:0] point_key;
  } lookup_rsp_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [63:0] cfg_wdata;

  chrl_req_if in_ch();
  chrl_rsp_if out_ch();

  consistent_hash_ring_lookup_core uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Ring model state
  logic [KEY_W-1:0] mdl_keys[RING_DEPTH];
  logic [NODE_W-1:0] mdl_nodes[RING_DEPTH];
  int unsigned mdl_count;
  int unsigned mdl_cursor;
  bit mdl_wrapped;
  logic [63:0] mdl_mask;

  lookup_req_t pending_reqs[$];
  lookup_rsp_t expected_rsps[$];
  logic [KEY_W-1:0] used_keys[$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  bit timed_out;
  bit stim_done;
  int unsigned in_gap;
  int unsigned out_gap;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned ring_lower_bound(logic [KEY_W-1:0] key);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = mdl_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (mdl_keys[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic bit cursor_node_up();
    return mdl_mask[mdl_nodes[mdl_cursor]];
  endfunction

  // Walk past down nodes; 0 means miss with cursor parked at ring end
  function automatic bit skip_down_nodes();
    int unsigned guard;
    guard = 2 * mdl_count + 2;
    while (!cursor_node_up()) begin
      mdl_cursor++;
      if (mdl_cursor >= mdl_count) begin
        if (!mdl_wrapped) begin
          mdl_wrapped = 1'b1;
          mdl_cursor = 0;
        end else begin
          mdl_cursor = mdl_count;
          return 1'b0;
        end
      end
      if (guard == 0) begin
        mdl_cursor = mdl_count;
        return 1'b0;
      end
      guard--;
    end
    return 1'b1;
  endfunction

  function automatic lookup_rsp_t predict_lookup(lookup_req_t rq);
    lookup_rsp_t rs;
    int unsigned p;
    bit hit;
    rs = '0;
    rs.status = ST_MISS;
    hit = 1'b0;
    if (rq.cmd == CMD_INSERT) begin
      p = ring_lower_bound(rq.key_hash);
      if (p < mdl_count && mdl_keys[p] == rq.key_hash) begin
        rs.status = ST_DUP;
        rs.chosen_node = mdl_nodes[p];
        rs.point_key = mdl_keys[p];
      end else if (mdl_count >= RING_DEPTH) begin
        rs.status = ST_FULL;
      end else begin
        for (int i = mdl_count; i > p; i--) begin
          mdl_keys[i] = mdl_keys[i-1];
          mdl_nodes[i] = mdl_nodes[i-1];
        end
        mdl_keys[p] = rq.key_hash;
        mdl_nodes[p] = rq.node_id % NODE_COUNT;
        mdl_count++;
        rs.status = ST_OK;
        rs.chosen_node = rq.node_id % NODE_COUNT;
        rs.point_key = rq.key_hash;
      end
    end else if (rq.cmd <= CMD_CONT_AVAIL && mdl_count > 0) begin
      if (rq.cmd == CMD_FIND || rq.cmd == CMD_FIND_AVAIL) begin
        mdl_wrapped = 1'b0;
        mdl_cursor = ring_lower_bound(rq.key_hash);
        if (mdl_cursor >= mdl_count) begin
          mdl_wrapped = 1'b1;
          mdl_cursor = 0;
        end
        hit = (rq.cmd == CMD_FIND) ? 1'b1 : skip_down_nodes();
      end else if (rq.cmd == CMD_NEXT) begin
        mdl_cursor++;
        if (mdl_cursor >= mdl_count) begin
          if (!mdl_wrapped) begin
            mdl_wrapped = 1'b1;
            mdl_cursor = 0;
            hit = 1'b1;
          end else begin
            mdl_cursor = mdl_count;
          end
        end else begin
          hit = 1'b1;
        end
      end else begin
        if (mdl_cursor >= mdl_count) begin
          mdl_wrapped = 1'b1;
          mdl_cursor = 0;
        end
        hit = skip_down_nodes();
      end
      if (hit) begin
        rs.status = ST_OK;
        rs.chosen_node = mdl_nodes[mdl_cursor];
        rs.point_key = mdl_keys[mdl_cursor];
      end
    end
    rs.wrapped_out = mdl_wrapped;
    return rs;
  endfunction

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // Random keys, or existing points and keys one past them, so lookups land on exact hits and duplicates
  function automatic logic [63:0] pick_key();
    int unsigned r;
    logic [63:0] k;
    r = $urandom_range(0, 9);
    if (used_keys.size() > 0 && r < 4) begin
      k = used_keys[$urandom_range(0, used_keys.size() - 1)];
      if (r == 3) k = k + 1;
      return k;
    end
    return rand_key();
  endfunction

  function automatic lookup_req_t make_req(logic [2:0] cmd, logic [63:0] key,
                                           logic [5:0] node);
    lookup_req_t rq;
    rq.cmd = cmd;
    rq.key_hash = key;
    rq.node_id = node;
    return rq;
  endfunction

  task automatic queue_req(logic [2:0] cmd, logic [63:0] key, logic [5:0] node);
    pending_reqs.push_back(make_req(cmd, key, node));
    if (cmd == CMD_INSERT) used_keys.push_back(key);
  endtask

  // Wait for all results plus the block's drain time, then load the mask
  task automatic write_mask(logic [63:0] value);
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    mdl_mask = value;
  endtask

  task automatic queue_random_phase(int unsigned n, int unsigned ins_weight);
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < ins_weight) queue_req(CMD_INSERT, pick_key(), 6'($urandom));
      else if (r < 97) queue_req(3'($urandom_range(1, 4)), pick_key(), 6'($urandom));
      else queue_req(3'($urandom_range(5, 7)), pick_key(), 6'($urandom));
    end
  endtask

  // Stimulus
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    stim_done = 1'b0;
    mdl_mask = '1;
    mdl_count = 0;
    mdl_cursor = 0;
    mdl_wrapped = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty ring misses, extremes, wraps, unknown commands
    queue_req(CMD_FIND, '0, 6'd0);
    queue_req(CMD_NEXT, '1, 6'd63);
    queue_req(CMD_FIND_AVAIL, '1, 6'd0);
    queue_req(CMD_CONT_AVAIL, '0, 6'd0);
    queue_req(3'd7, '1, 6'd63);
    queue_req(CMD_INSERT, 64'h8000_0000_0000_0000, 6'd5);
    queue_req(CMD_INSERT, '0, 6'd0);
    queue_req(CMD_INSERT, '1, 6'd63);
    queue_req(CMD_INSERT, '1, 6'd1);
    queue_req(CMD_INSERT, 64'h0000_0000_FFFF_FFFF, 6'd42);
    queue_req(CMD_FIND, '1, 6'd0);
    queue_req(CMD_NEXT, '0, 6'd0);
    queue_req(CMD_NEXT, '0, 6'd0);
    queue_req(CMD_NEXT, '0, 6'd0);
    queue_req(CMD_FIND, 64'h8000_0000_0000_0001, 6'd0);
    queue_req(CMD_NEXT, '0, 6'd0);
    queue_req(CMD_NEXT, '0, 6'd0);
    queue_req(CMD_NEXT, '0, 6'd0);
    queue_req(CMD_CONT_AVAIL, '0, 6'd0);
    queue_req(CMD_FIND_AVAIL, 64'h1, 6'd0);
    queue_req(3'd5, '0, 6'd0);
    queue_req(3'd6, '0, 6'd0);

    // Some nodes down: skips and double-wrap misses
    write_mask(~((64'd1 << 5) | (64'd1 << 63) | 64'd1));
    queue_req(CMD_FIND_AVAIL, '1, 6'd0);
    queue_req(CMD_CONT_AVAIL, '0, 6'd0);
    queue_req(CMD_CONT_AVAIL, '0, 6'd0);
    write_mask('0);
    queue_req(CMD_FIND_AVAIL, '0, 6'd0);
    queue_req(CMD_CONT_AVAIL, '0, 6'd0);
    write_mask('1);

    // Random phases over several masks; fill the ring to full in the middle
    queue_random_phase(300, 35);
    write_mask({$urandom, $urandom});
    queue_random_phase(300, 60);
    write_mask({$urandom, $urandom} & {$urandom, $urandom});
    queue_random_phase(300, 30);
    write_mask(64'd1 << $urandom_range(0, 63));
    queue_random_phase(200, 20);
    write_mask('0);
    queue_random_phase(100, 10);
    write_mask({$urandom, $urandom} | {$urandom, $urandom});
    queue_random_phase(250, 30);
    while (pending_reqs.size() > 0) @(posedge clk);
    stim_done = 1'b1;
  end

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.cmd <= '0;
      in_ch.key_hash <= '0;
      in_ch.node_id <= '0;
      in_gap <= 0;
    end else begin
      // the accepted transaction leaves the queue; the head is the next one
      if (in_ch.valid && in_ch.ready) begin
        expected_rsps.push_back(predict_lookup(pending_reqs.pop_front()));
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the current transaction
      end else if (in_gap > 0) begin
        in_ch.valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        lookup_req_t nx;
        nx = pending_reqs[0];
        in_ch.valid <= 1'b1;
        in_ch.cmd <= nx.cmd;
        in_ch.key_hash <= nx.key_hash;
        in_ch.node_id <= nx.node_id;
        in_gap <= gap_len();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.key_hash = '0;
    in_ch.node_id = '0;
    out_ch.ready = 1'b0;
  end

  // Monitor and ready pacing
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
      mismatch_count <= 0;
    end else begin
      if (out_gap > 0) begin
        out_ch.ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap <= gap_len();
      end
      if (out_ch.valid && out_ch.ready) begin
        lookup_rsp_t got, want;
        got.status = status_t'(out_ch.status);
        got.chosen_node = out_ch.chosen_node;
        got.wrapped_out = out_ch.wrapped_out;
        got.point_key = out_ch.point_key;
        if (expected_rsps.size() == 0) begin
          if (mismatch_count < 10)
            $display("Unexpected result transaction: %p", got);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_rsps.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10)
              $display("Result mismatch: expected %p actual %p", want, got);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no accepted transaction
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    timed_out = 1'b0;
    idle_cycles = 0;
    fork
      begin
        wait (stim_done);
        while (expected_rsps.size() > 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
      end
      begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        timed_out = 1'b1;
      end
    join_any
    if (!timed_out && mismatch_count == 0 && expected_rsps.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
